// File: hdl/mbep_pkg.sv
// ----------------------------------------------------------------------------
// Masked bit extract packer package
// Shared types and constants for the front classifier, the queue and the
// packing back end.
// ----------------------------------------------------------------------------
package mbep_pkg;

  // Fixed field widths of the item and result transfers.
  localparam int MAX_WORD_BITS = 64;
  localparam int VALID_W       = 7;
  localparam int COUNT_W       = 32;

  // Default word width and queue depth handed to the top level.
  localparam int DEF_WORD_BITS   = 64;
  localparam int DEF_QUEUE_DEPTH = 4;

  // Extraction is done per byte lane in the front end.
  localparam int LANE_BITS  = 8;
  localparam int LANE_IDX_W = 3;
  localparam int LANE_CNT_W = 4;
  localparam int MAX_LANES  = MAX_WORD_BITS / LANE_BITS;

  typedef struct packed {
    logic [MAX_WORD_BITS-1:0] mask_word;
    logic [MAX_WORD_BITS-1:0] data_word;
    logic [VALID_W-1:0]       valid_bits;
    logic                     last;
  } item_t;

  typedef struct packed {
    logic [MAX_WORD_BITS-1:0] packed_word;
    logic [VALID_W-1:0]       word_bits;
    logic                     final_res;
    logic                     bad_bit;
    logic [COUNT_W-1:0]       extracted_count;
  } result_t;

  // Classified word as it travels from the front end to the back end.
  typedef struct packed {
    logic [MAX_LANES-1:0][LANE_BITS-1:0]  lane_ext;
    logic [MAX_LANES-1:0][LANE_CNT_W-1:0] lane_cnt;
    logic                                 bad;
    logic                                 last;
  } front_item_t;

endpackage

// File: hdl/mbep_front.sv
// ----------------------------------------------------------------------------
// Masked bit extract packer front end
// Trims each word to its valid positions, checks for data bits outside the
// mask and extracts the masked data bits lane by lane.
// ----------------------------------------------------------------------------
module mbep_front
  import mbep_pkg::*;
#(
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  item_t       item,
  output front_item_t cls
);

  localparam int NLANE = (WORD_BITS + LANE_BITS - 1) / LANE_BITS;
  localparam int PADW  = NLANE * LANE_BITS;

  logic [VALID_W-1:0]    vclip;
  logic [PADW-1:0]       mk;
  logic [PADW-1:0]       dt;
  logic [LANE_CNT_W-1:0] c;
  logic [LANE_BITS-1:0]  e;

  always_comb begin
    if (item.valid_bits > VALID_W'(WORD_BITS)) begin
      vclip = VALID_W'(WORD_BITS);
    end else begin
      vclip = item.valid_bits;
    end
  end

  // Positions beyond the word width or beyond the valid count are dropped.
  always_comb begin
    mk = '0;
    dt = '0;
    for (int i = 0; i < PADW; i++) begin
      if (i < WORD_BITS && VALID_W'(i) < vclip) begin
        mk[i] = item.mask_word[i];
        dt[i] = item.data_word[i];
      end
    end
  end

  always_comb begin
    cls      = '0;
    cls.bad  = |(dt & ~mk);
    cls.last = item.last;
    for (int j = 0; j < NLANE; j++) begin
      c = '0;
      e = '0;
      for (int b = 0; b < LANE_BITS; b++) begin
        if (mk[j*LANE_BITS+b]) begin
          e[c[LANE_IDX_W-1:0]] = dt[j*LANE_BITS+b];
          c = c + LANE_CNT_W'(1);
        end
      end
      cls.lane_ext[j] = e;
      cls.lane_cnt[j] = c;
    end
  end

endmodule

// File: hdl/mbep_queue.sv
// ----------------------------------------------------------------------------
// Masked bit extract packer queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module mbep_queue
  import mbep_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  front_item_t push_item,
  output logic        full,
  input  logic        pop,
  output logic        not_empty,
  output front_item_t head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  front_item_t        entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: hdl/mbep_back.sv
// ----------------------------------------------------------------------------
// Masked bit extract packer back end
// Merges the lane extracts into one run of bits, appends it to the pack
// buffer and emits full and flushed words through an output register.
// ----------------------------------------------------------------------------
module mbep_back
  import mbep_pkg::*;
#(
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  front_item_t q_item,
  input  logic        q_valid,
  output logic        q_pop,
  output result_t     result,
  output logic        result_valid,
  input  logic        result_stall
);

  localparam int NLANE = (WORD_BITS + LANE_BITS - 1) / LANE_BITS;
  localparam int CW    = $clog2(WORD_BITS + 1);
  localparam int SW    = WORD_BITS + LANE_BITS;

  // Merge stage.
  logic [CW-1:0]        off;
  logic [SW-1:0]        acc;
  logic                 m_valid;
  logic [WORD_BITS-1:0] m_ext;
  logic [CW-1:0]        m_k;
  logic                 m_bad;
  logic                 m_last;
  logic                 m_load;
  logic                 m_take;

  // Pack stage.
  logic [WORD_BITS-1:0]   buffer;
  logic [CW-1:0]          fill;
  logic                   bad_seen;
  logic [COUNT_W-1:0]     total;
  logic                   pend_valid;
  result_t                pend;
  logic                   o_free;
  logic                   bad_next;
  logic [COUNT_W:0]       sum;
  logic [COUNT_W-1:0]     total_next;
  logic [2*WORD_BITS-1:0] wide;
  logic [WORD_BITS-1:0]   head;
  logic [CW:0]            bits_sum;
  logic                   full;
  logic [WORD_BITS-1:0]   buffer_next;
  logic [CW-1:0]          fill_next;
  result_t                full_res;
  result_t                flush_res;
  logic                   two;
  logic                   produce;

  // Each lane lands at the running count of the lanes below it.
  always_comb begin
    off = '0;
    acc = '0;
    for (int j = 0; j < NLANE; j++) begin
      acc = acc | (SW'(q_item.lane_ext[j]) << off);
      off = off + CW'(q_item.lane_cnt[j]);
    end
  end

  assign o_free = !result_valid || !result_stall;
  assign m_take = m_valid && !pend_valid && o_free;
  assign m_load = !m_valid || m_take;
  assign q_pop  = q_valid && m_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (m_load) begin
      m_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_ext  <= acc[WORD_BITS-1:0];
      m_k    <= off;
      m_bad  <= q_item.bad;
      m_last <= q_item.last;
    end
  end

  always_comb begin
    bad_next   = bad_seen | m_bad;
    sum        = {1'b0, total} + (COUNT_W+1)'(m_k);
    total_next = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];

    wide     = {{WORD_BITS{1'b0}}, m_ext} << fill;
    head     = buffer | wide[WORD_BITS-1:0];
    bits_sum = (CW+1)'(fill) + (CW+1)'(m_k);
    full     = (bits_sum >= (CW+1)'(WORD_BITS));

    if (full) begin
      buffer_next = wide[2*WORD_BITS-1:WORD_BITS];
      fill_next   = CW'(bits_sum - (CW+1)'(WORD_BITS));
    end else begin
      buffer_next = head;
      fill_next   = CW'(bits_sum);
    end

    full_res.packed_word     = MAX_WORD_BITS'(head);
    full_res.word_bits       = VALID_W'(WORD_BITS);
    full_res.final_res       = m_last && (fill_next == '0);
    full_res.bad_bit         = bad_next;
    full_res.extracted_count = total_next;

    flush_res.packed_word     = MAX_WORD_BITS'(buffer_next);
    flush_res.word_bits       = VALID_W'(fill_next);
    flush_res.final_res       = 1'b1;
    flush_res.bad_bit         = bad_next;
    flush_res.extracted_count = total_next;

    produce = full || m_last;
    two     = full && m_last && (fill_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      pend_valid   <= 1'b0;
      buffer       <= '0;
      fill         <= '0;
      bad_seen     <= 1'b0;
      total        <= '0;
    end else begin
      if (pend_valid) begin
        if (o_free) begin
          result       <= pend;
          result_valid <= 1'b1;
          pend_valid   <= 1'b0;
        end
      end else if (m_take) begin
        result_valid <= produce;
        result       <= full ? full_res : flush_res;
        pend_valid   <= two;
        pend         <= flush_res;
        if (m_last) begin
          buffer   <= '0;
          fill     <= '0;
          bad_seen <= 1'b0;
          total    <= '0;
        end else begin
          buffer   <= buffer_next;
          fill     <= fill_next;
          bad_seen <= bad_next;
          total    <= total_next;
        end
      end else if (o_free) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/masked_bit_extract_packer.sv
// A result passes through the queue, the merge register and the output register in turn.
// Throughput: one word per cycle while the output is not stalled; a word that yields a full
// word and a flush sends two results, and the four-entry queue absorbs that and output stalls.
// Reset clears the queue, the merge stage, the output register and all packing state, so the
// block comes out of reset with an empty buffer, a clear error flag and a zero count.
// ----------------------------------------------------------------------------
// Masked bit extract packer
// Streaming parallel bit extract: the data bits under each set mask bit are
// packed into a continuous output stream of words.
// ----------------------------------------------------------------------------
module masked_bit_extract_packer
  import mbep_pkg::*;
#(
  parameter int WORD_BITS   = DEF_WORD_BITS,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  // The front end is purely combinational: every word that arrives is
  // trimmed, checked and split into per-byte extracts, and the classified
  // word is written straight into the queue. The input is therefore only
  // stalled when the queue is full.
  front_item_t cls;
  front_item_t q_head;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  logic        q_push;

  mbep_front #(
    .WORD_BITS(WORD_BITS)
  ) u_front (
    .item(item),
    .cls (cls)
  );

  assign item_stall = q_full;
  assign q_push     = item_valid && !q_full;

  // The queue lets the back end stall on a busy output without holding off
  // transfers on the input side until it has filled.
  mbep_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_item(cls),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_valid),
    .head     (q_head)
  );

  // The back end merges the lane extracts in one register stage, then
  // appends them to the pack buffer. A word that fills the buffer and also
  // ends the string leaves its flush result in a holding register that is
  // sent in the following transfer.
  mbep_back #(
    .WORD_BITS(WORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_item      (q_head),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .result      (result),
    .result_valid(result_valid),
    .result_stall(result_stall)
  );

endmodule

// File: hdl/mbep_checker.sv
// ----------------------------------------------------------------------------
// Masked bit extract packer checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module mbep_checker
  import mbep_pkg::*;
#(
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input logic    clk,
  input logic    rst,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // A stalled result stays offered.
  a_hold_valid : assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result withdrawn while stalled");

  // Only the result that ends a string may be a partial word.
  a_full_word : assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.final_res |-> result.word_bits == VALID_W'(WORD_BITS))
    else $error("non-final result is not a full word");

  // Bits above the meaningful count are zero.
  a_clean_top : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.packed_word >> result.word_bits) == '0)
    else $error("packed word has stray high bits");

endmodule

bind masked_bit_extract_packer mbep_checker #(
  .WORD_BITS(WORD_BITS)
) u_checker (
  .clk         (clk),
  .rst         (rst),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .result      (result)
);

// File: bench/masked_bit_extract_packer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked bit extract packer test
// Streams bit strings through the packer, predicts every packed word, flush,
// error flag and running count in a behavioural model kept in step with each
// accepted word transfer, and checks each result transfer against it. Both
// handshakes are disturbed by random idle gaps and output stalls.
// ----------------------------------------------------------------------------
module masked_bit_extract_packer_test;
  import mbep_pkg::*;

  // The block is built with its default word width, so the model uses it too.
  localparam int PACK_BITS = DEF_WORD_BITS;
  localparam logic [MAX_WORD_BITS-1:0] WIDTH_MASK =
    {MAX_WORD_BITS{1'b1}} >> (MAX_WORD_BITS - PACK_BITS);

  // Every input is given a known value from time zero.
  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_stall;
  item_t   word_in      = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  masked_bit_extract_packer dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (word_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Words waiting to be sent, and the results the model says must come back,
  // oldest first.
  item_t   words_to_send[$];
  result_t expected_results[$];

  // Model state: the partly filled output word, its fill level, the sticky
  // error flag and the saturating count of extracted bits for this string.
  logic [MAX_WORD_BITS-1:0] pack_buf       = '0;
  int                       pack_fill      = 0;
  bit                       err_flag       = 1'b0;
  logic [COUNT_W-1:0]       bits_extracted = '0;

  int mismatches      = 0;
  int words_accepted  = 0;
  int strings_ended   = 0;
  int results_checked = 0;
  int flagged_results = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: mismatch on %s, got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // Gathers the data bits under the set mask bits of one word, appends them
  // to the packing buffer and queues the results that this word produces.
  function automatic void extract_and_pack(item_t w);
    logic [MAX_WORD_BITS-1:0] mask_in;
    logic [MAX_WORD_BITS-1:0] data_in;
    logic [MAX_WORD_BITS-1:0] gathered;
    logic [MAX_WORD_BITS-1:0] head;
    logic [COUNT_W:0]         sum;
    int                       span;
    int                       k;
    int                       total;
    bit                       have_full;
    result_t                  full_word;
    result_t                  flush;
    mask_in   = w.mask_word & WIDTH_MASK;
    data_in   = w.data_word & WIDTH_MASK;
    span      = int'(w.valid_bits);
    gathered  = '0;
    k         = 0;
    have_full = 1'b0;
    full_word = '0;
    flush     = '0;
    // A count beyond the word width is clamped; positions above it are ignored
    // entirely, including for the error check.
    if (span > PACK_BITS) begin
      span = PACK_BITS;
    end
    for (int i = 0; i < span; i++) begin
      if (mask_in[i]) begin
        gathered[k] = data_in[i];
        k++;
      end else if (data_in[i]) begin
        err_flag = 1'b1;
      end
    end
    sum = {1'b0, bits_extracted} + (COUNT_W+1)'(k);
    bits_extracted = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];

    head  = (pack_buf | (gathered << pack_fill)) & WIDTH_MASK;
    total = pack_fill + k;
    if (total >= PACK_BITS) begin
      // The buffer overflowed: the full word goes out and the spill-over
      // starts the next one.
      have_full                 = 1'b1;
      full_word.packed_word     = head;
      full_word.word_bits       = VALID_W'(PACK_BITS);
      full_word.final_res       = 1'b0;
      full_word.bad_bit         = err_flag;
      full_word.extracted_count = bits_extracted;
      pack_buf  = (pack_fill == 0) ? '0 : ((gathered >> (PACK_BITS - pack_fill)) & WIDTH_MASK);
      pack_fill = total - PACK_BITS;
    end else begin
      pack_buf  = head;
      pack_fill = total;
    end

    if (w.last) begin
      if (have_full && pack_fill == 0) begin
        // Nothing left over, so the full word itself closes the string.
        full_word.final_res = 1'b1;
        expected_results.push_back(full_word);
      end else begin
        if (have_full) begin
          expected_results.push_back(full_word);
        end
        flush.packed_word     = pack_buf;
        flush.word_bits       = VALID_W'(pack_fill);
        flush.final_res       = 1'b1;
        flush.bad_bit         = err_flag;
        flush.extracted_count = bits_extracted;
        expected_results.push_back(flush);
      end
      pack_buf       = '0;
      pack_fill      = 0;
      err_flag       = 1'b0;
      bits_extracted = '0;
    end else if (have_full) begin
      expected_results.push_back(full_word);
    end
  endfunction

  function automatic item_t word_item(logic [63:0] m, logic [63:0] d, int v, bit l);
    item_t w;
    w.mask_word  = m;
    w.data_word  = d;
    w.valid_bits = VALID_W'(v);
    w.last       = l;
    return w;
  endfunction

  function automatic logic [63:0] random_dword();
    return {$urandom, $urandom};
  endfunction

  // One word of a random string. Most words are fully valid with data lying
  // under the mask; a minority carry short or out-of-range counts, or stray
  // data bits that should raise the error flag.
  function automatic item_t random_word(bit l);
    logic [63:0] m;
    logic [63:0] d;
    int          v;
    int          pick;
    pick = $urandom_range(0, 19);
    if (pick < 15) begin
      v = PACK_BITS;
    end else if (pick < 18) begin
      v = $urandom_range(1, 63);
    end else if (pick == 18) begin
      v = 0;
    end else begin
      v = $urandom_range(65, 127);
    end
    case ($urandom_range(0, 5))
      0: begin
        m = '1;
      end
      1: begin
        m = '0;
      end
      2: begin
        m = random_dword();
      end
      3: begin
        m = random_dword() & random_dword() & random_dword();
      end
      4: begin
        m = random_dword() | random_dword();
      end
      default: begin
        m = ({64{1'b1}} << $urandom_range(0, 63)) & ({64{1'b1}} >> $urandom_range(0, 63));
      end
    endcase
    pick = $urandom_range(0, 19);
    if (pick < 16) begin
      d = random_dword() & m;
    end else if (pick < 18) begin
      d = random_dword();
    end else begin
      d = (random_dword() & m) | (64'h1 << $urandom_range(0, 63));
    end
    return word_item(m, d, v, l);
  endfunction

  // Idle gap lengths: mostly none or short, a few long, with occasional calm
  // stretches in which no gap is taken at all.
  function automatic int pick_idle(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm = $urandom_range(20, 80);
    end
    if (r < 55) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Driver. A word is predicted at the edge where its transfer happens; a new
  // word is presented only once the previous one has gone or valid is low,
  // so a stalled payload never changes.
  int send_gap  = 0;
  int send_calm = 0;

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        extract_and_pack(word_in);
        words_accepted++;
      end
      if (!item_valid || !item_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          item_valid <= 1'b0;
        end else if (words_to_send.size() != 0) begin
          item_valid <= 1'b1;
          word_in    <= words_to_send.pop_front();
          send_gap    = pick_idle(send_calm);
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every result transfer is compared field by field with the
  // oldest outstanding prediction; the output is stalled at random.
  int stall_left = 0;
  int stall_calm = 0;

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", result.packed_word, '0);
        end else begin
          result_t want;
          want = expected_results.pop_front();
          results_checked++;
          if (want.final_res) begin
            strings_ended++;
          end
          if (want.bad_bit) begin
            flagged_results++;
          end
          if (result.packed_word !== want.packed_word) begin
            report_mismatch("packed_word", result.packed_word, want.packed_word);
          end
          if (result.word_bits !== want.word_bits) begin
            report_mismatch("word_bits", result.word_bits, want.word_bits);
          end
          if (result.final_res !== want.final_res) begin
            report_mismatch("final_res", result.final_res, want.final_res);
          end
          if (result.bad_bit !== want.bad_bit) begin
            report_mismatch("bad_bit", result.bad_bit, want.bad_bit);
          end
          if (result.extracted_count !== want.extracted_count) begin
            report_mismatch("extracted_count", result.extracted_count,
                            want.extracted_count);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
        stall_left    = pick_idle(stall_calm);
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int n_words;
    // Directed words first: a full word that closes its string, an empty
    // string, a single-bit flush, a word that yields both a full word and a
    // flush, two half words meeting exactly at the word boundary, stray data
    // bits, bits beyond the valid count, zero and clamped counts, and the
    // highest position on its own.
    words_to_send.push_back(word_item('1, '1, 64, 1'b1));
    words_to_send.push_back(word_item('0, '0, 64, 1'b1));
    words_to_send.push_back(word_item('1, '0, 64, 1'b0));
    words_to_send.push_back(word_item('1, 64'h1, 1, 1'b1));
    words_to_send.push_back(word_item(64'h00FF_FFFF_FFFF, 64'h00A5_A5A5_A5A5, 40, 1'b0));
    words_to_send.push_back(word_item('1, '1, 40, 1'b1));
    words_to_send.push_back(word_item(64'h0000_0000_FFFF_FFFF, 64'h1234_5678_9ABC_DEF0,
                                      64, 1'b0));
    words_to_send.push_back(word_item(64'hFFFF_FFFF_0000_0000, 64'hFEDC_BA98_7654_3210,
                                      64, 1'b1));
    words_to_send.push_back(word_item(64'h0F, 64'hF0, 8, 1'b0));
    words_to_send.push_back(word_item('1, '1, 64, 1'b1));
    words_to_send.push_back(word_item('0, 64'hFFFF_0000_0000_0000, 16, 1'b1));
    words_to_send.push_back(word_item('1, '1, 0, 1'b1));
    words_to_send.push_back(word_item('1, 64'h8000_0000_0000_0001, 127, 1'b1));
    words_to_send.push_back(word_item('1, '1, 65, 1'b0));
    words_to_send.push_back(word_item({32{2'b10}}, {32{2'b01}}, 64, 1'b1));
    words_to_send.push_back(word_item(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
                                      64, 1'b0));
    words_to_send.push_back(word_item(64'h1, '0, 1, 1'b1));
    words_to_send.push_back(word_item('1, '1, 100, 1'b1));

    // Random strings, mostly short, some long enough to fill many words.
    while (words_to_send.size() < 1400) begin
      n_words = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int w = 0; w < n_words; w++) begin
        words_to_send.push_back(random_word(w == n_words - 1));
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (words_to_send.size() != 0 || item_valid) begin
      @(posedge clk);
    end
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
    // Allow for the pipeline latency so that any stray extra result shows up.
    repeat (10) @(posedge clk);

    $display("Sent %0d words forming %0d strings; checked %0d results.",
             words_accepted, strings_ended, results_checked);
    $display("%0d results carried the error flag.", flagged_results);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Safety net in case the block stops making progress.
  initial begin
    #20_000_000;
    $display("Timed out waiting for the block.");
    $display("DONE: errors detected");
    $finish;
  end

endmodule
